[design/bspd_pkg.sv]
`default_nettype none
package bspd_pkg;

  localparam int unsigned SymW   = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned SyncW  = 32;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned OutW   = 64;

  localparam logic [2:0] RegSyncWord  = 3'd0;
  localparam logic [2:0] RegFlagPat   = 3'd1;
  localparam logic [2:0] RegFlagWin   = 3'd2;
  localparam logic [2:0] RegCrcSeed   = 3'd3;
  localparam logic [2:0] RegCrcPoly   = 3'd4;

  localparam logic [SyncW-1:0] SyncWordRst = 32'h5555_5555;
  localparam logic [ByteW-1:0] FlagPatRst  = 8'h7E;
  localparam logic [ByteW-1:0] FlagWinRst  = 8'd32;
  localparam logic [CrcW-1:0]  CrcSeedRst  = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPolyRst  = 16'h1021;

  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef struct packed {
    logic [SyncW-1:0] sync_word;
    logic [ByteW-1:0] flag_pattern;
    logic [ByteW-1:0] flag_window;
    logic [CrcW-1:0]  crc_seed;
    logic [CrcW-1:0]  crc_polynomial;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] packet_length;
    logic             crc_good;
    logic [CrcW-1:0]  received_crc;
    logic [CrcW-1:0]  computed_crc;
  } result_t;

  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b,
                                               input logic [CrcW-1:0] poly);
    logic [CrcW-1:0] c;
    logic            top;
    c = crc;
    for (int i = 0; i < ByteW; i++) begin
      top = c[CrcW-1] ^ b[ByteW-1-i];
      c = {c[CrcW-2:0], 1'b0};
      if (top) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[design/bspd_deframe.sv]
`default_nettype none
module bspd_deframe (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic [bspd_pkg::SymW-1:0]     symbol,
  input  wire bspd_pkg::cfg_t                cfg,
  output logic                               res_valid,
  output bspd_pkg::result_t                  res
);

  typedef enum logic [2:0] {
    PH_SYNC = 3'd0,
    PH_FLAG = 3'd1,
    PH_LEN  = 3'd2,
    PH_PAY  = 3'd3,
    PH_CRC  = 3'd4
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [bspd_pkg::SyncW-1:0]      sync_r, sync_nxt;
  logic [bspd_pkg::ByteW-1:0]      flag_r, flag_nxt;
  logic [bspd_pkg::ByteW-1:0]      pos_r, pos_nxt;
  logic [bspd_pkg::ByteW-1:0]      cnt_r, cnt_nxt;
  logic [bspd_pkg::ByteW-1:0]      len_r, len_nxt;
  logic [bspd_pkg::ByteW-1:0]      acc_r, acc_nxt;
  logic [bspd_pkg::CrcW-1:0]       crc_r, crc_nxt;
  logic [bspd_pkg::CrcW-1:0]       rxcrc_r, rxcrc_nxt;

  logic                            is_bit;
  logic                            bit_in;
  logic [bspd_pkg::SyncW-1:0]      sync_sh;
  logic [bspd_pkg::ByteW-1:0]      flag_sh;
  logic [bspd_pkg::ByteW-1:0]      len_sh;
  logic [bspd_pkg::ByteW-1:0]      acc_base;
  logic [bspd_pkg::ByteW-1:0]      acc_sh;
  logic [bspd_pkg::CrcW-1:0]       rxcrc_sh;
  logic [bspd_pkg::ByteW-1:0]      crc_data;
  logic [bspd_pkg::CrcW-1:0]       crc_upd;
  logic [bspd_pkg::ByteW-1:0]      pos_inc;
  logic [bspd_pkg::ByteW-1:0]      cnt_inc;

  assign is_bit   = (symbol == bspd_pkg::SymW'(0)) || (symbol == bspd_pkg::SymW'(1));
  assign bit_in   = symbol[0];
  assign sync_sh  = is_bit ? {sync_r[bspd_pkg::SyncW-2:0], bit_in} : sync_r;
  assign flag_sh  = is_bit ? {flag_r[bspd_pkg::ByteW-2:0], bit_in} : flag_r;
  assign len_sh   = is_bit ? {len_r[bspd_pkg::ByteW-2:0], bit_in} : len_r;
  assign acc_base = (pos_r == '0) ? '0 : acc_r;
  assign acc_sh   = is_bit ? {acc_base[bspd_pkg::ByteW-2:0], bit_in} : acc_base;
  assign rxcrc_sh = is_bit ? {rxcrc_r[bspd_pkg::CrcW-2:0], bit_in} : rxcrc_r;
  assign crc_data = (phase_r == PH_LEN) ? len_sh : acc_sh;
  assign crc_upd  = bspd_pkg::crc_byte(crc_r, crc_data, cfg.crc_polynomial);
  assign pos_inc  = pos_r + 8'd1;
  assign cnt_inc  = cnt_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    sync_nxt  = sync_r;
    flag_nxt  = flag_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    crc_nxt   = crc_r;
    rxcrc_nxt = rxcrc_r;
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_SYNC: begin
        sync_nxt = sync_sh;
        if (sync_sh == cfg.sync_word) begin
          phase_nxt = PH_FLAG;
        end
      end
      PH_FLAG: begin
        if (pos_r < cfg.flag_window) begin
          flag_nxt = flag_sh;
          pos_nxt  = pos_inc;
          if (flag_sh == cfg.flag_pattern) begin
            pos_nxt   = '0;
            crc_nxt   = cfg.crc_seed;
            phase_nxt = PH_LEN;
          end
        end else begin
          phase_nxt = PH_SYNC;
          sync_nxt  = '0;
          flag_nxt  = '0;
          pos_nxt   = '0;
          cnt_nxt   = '0;
          len_nxt   = '0;
          acc_nxt   = '0;
          crc_nxt   = cfg.crc_seed;
          rxcrc_nxt = '0;
        end
      end
      PH_LEN: begin
        len_nxt = len_sh;
        pos_nxt = pos_inc;
        if (pos_r >= 8'd7) begin
          pos_nxt   = '0;
          crc_nxt   = crc_upd;
          cnt_nxt   = '0;
          acc_nxt   = '0;
          phase_nxt = (len_sh == '0) ? PH_CRC : PH_PAY;
        end
      end
      PH_PAY: begin
        acc_nxt = acc_sh;
        pos_nxt = pos_inc;
        if (pos_r >= 8'd7) begin
          res_valid         = 1'b1;
          res.kind          = bspd_pkg::KindByte;
          res.payload_byte  = acc_sh;
          res.byte_index    = cnt_r;
          res.packet_length = len_r;
          crc_nxt           = crc_upd;
          pos_nxt           = '0;
          cnt_nxt           = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = PH_CRC;
          end
        end
      end
      PH_CRC: begin
        rxcrc_nxt = rxcrc_sh;
        pos_nxt   = pos_inc;
        if (pos_r >= 8'd15) begin
          res_valid         = 1'b1;
          res.kind          = bspd_pkg::KindEnd;
          res.packet_length = len_r;
          res.crc_good      = (crc_r == rxcrc_sh);
          res.received_crc  = rxcrc_sh;
          res.computed_crc  = crc_r;
          phase_nxt         = PH_SYNC;
          sync_nxt          = '0;
          flag_nxt          = '0;
          pos_nxt           = '0;
          cnt_nxt           = '0;
          len_nxt           = '0;
          acc_nxt           = '0;
          crc_nxt           = cfg.crc_seed;
          rxcrc_nxt         = '0;
        end
      end
      default: begin
        phase_nxt = PH_SYNC;
        sync_nxt  = '0;
        flag_nxt  = '0;
        pos_nxt   = '0;
        cnt_nxt   = '0;
        len_nxt   = '0;
        acc_nxt   = '0;
        crc_nxt   = cfg.crc_seed;
        rxcrc_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC;
      sync_r  <= '0;
      flag_r  <= '0;
      pos_r   <= '0;
      cnt_r   <= '0;
      len_r   <= '0;
      acc_r   <= '0;
      crc_r   <= bspd_pkg::CrcSeedRst;
      rxcrc_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      sync_r  <= sync_nxt;
      flag_r  <= flag_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      acc_r   <= acc_nxt;
      crc_r   <= crc_nxt;
      rxcrc_r <= rxcrc_nxt;
    end
  end

endmodule
`default_nettype wire

[design/bit_stream_packet_deframer_crc16_core.sv]
// Path: a symbol accepted into the input register is decoded at the edge where the decoder
//   advances; that edge loads any result into the output register and raises out_tvalid.
// Throughput: one symbol per cycle; the decode register stalls only while a result
//   waits in the output register and out_tready is low.
// Reset: synchronous on rst_n low; hunt for sync, state and config take their defaults.
`default_nettype none
module bit_stream_packet_deframer_crc16_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bspd_pkg::SymW-1:0]         in_tdata,   // [7:0] symbol
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [7:0] payload_byte, [15:8] byte_index, [23:16] packet_length, [24] crc_good,
  // [40:25] received_crc, [56:41] computed_crc, [63:57] zero
  output logic [bspd_pkg::OutW-1:0]              out_tdata,
  output logic                                   out_tuser,  // [0] kind
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [bspd_pkg::AddrW-1:0]        cfg_paddr,
  input  wire logic [bspd_pkg::DataW-1:0]        cfg_pwdata,
  output logic [bspd_pkg::DataW-1:0]             cfg_prdata,
  output logic                                   cfg_pready
);

  bspd_pkg::cfg_t               cfg_r;
  logic                         in_valid_r;
  logic [bspd_pkg::SymW-1:0]    in_symbol_r;
  logic                         out_valid_r;
  bspd_pkg::result_t            out_res_r;

  logic                         res_valid;
  bspd_pkg::result_t            res;
  logic                         out_free;
  logic                         dec_adv;
  logic                         cfg_wr;
  logic [2:0]                   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[bspd_pkg::AddrW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_word      <= bspd_pkg::SyncWordRst;
      cfg_r.flag_pattern   <= bspd_pkg::FlagPatRst;
      cfg_r.flag_window    <= bspd_pkg::FlagWinRst;
      cfg_r.crc_seed       <= bspd_pkg::CrcSeedRst;
      cfg_r.crc_polynomial <= bspd_pkg::CrcPolyRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bspd_pkg::RegSyncWord: cfg_r.sync_word      <= cfg_pwdata;
        bspd_pkg::RegFlagPat:  cfg_r.flag_pattern   <= cfg_pwdata[bspd_pkg::ByteW-1:0];
        bspd_pkg::RegFlagWin:  cfg_r.flag_window    <= cfg_pwdata[bspd_pkg::ByteW-1:0];
        bspd_pkg::RegCrcSeed:  cfg_r.crc_seed       <= cfg_pwdata[bspd_pkg::CrcW-1:0];
        bspd_pkg::RegCrcPoly:  cfg_r.crc_polynomial <= cfg_pwdata[bspd_pkg::CrcW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bspd_pkg::RegSyncWord: cfg_prdata = cfg_r.sync_word;
      bspd_pkg::RegFlagPat:  cfg_prdata = bspd_pkg::DataW'(cfg_r.flag_pattern);
      bspd_pkg::RegFlagWin:  cfg_prdata = bspd_pkg::DataW'(cfg_r.flag_window);
      bspd_pkg::RegCrcSeed:  cfg_prdata = bspd_pkg::DataW'(cfg_r.crc_seed);
      bspd_pkg::RegCrcPoly:  cfg_prdata = bspd_pkg::DataW'(cfg_r.crc_polynomial);
      default:               cfg_prdata = '0;
    endcase
  end

  assign out_free  = !out_valid_r || out_tready;
  assign dec_adv   = in_valid_r && (!res_valid || out_free);
  assign in_tready = !in_valid_r || dec_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_symbol_r <= in_tdata;
    end
  end

  bspd_deframe u_deframe (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (dec_adv),
    .symbol    (in_symbol_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dec_adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {7'd0, out_res_r.computed_crc, out_res_r.received_crc,
                       out_res_r.crc_good, out_res_r.packet_length,
                       out_res_r.byte_index, out_res_r.payload_byte};

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned LongStall    = 400;
  localparam int unsigned RandomItems  = 1350;

  typedef enum logic [2:0] {HuntSync, SeekFlag, ReadLen, ReadBody, ReadCrc} deframe_mode_t;

  logic                            clk;
  logic                            rst_n       = 1'b0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [bspd_pkg::SymW-1:0]       in_tdata    = '0;  // [7:0] symbol
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  // [7:0] payload_byte, [15:8] byte_index, [23:16] packet_length, [24] crc_good,
  // [40:25] received_crc, [56:41] computed_crc, [63:57] zero
  logic [bspd_pkg::OutW-1:0]       out_tdata;
  logic                            out_tuser;         // [0] kind
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [bspd_pkg::AddrW-1:0]      cfg_paddr   = '0;
  logic [bspd_pkg::DataW-1:0]      cfg_pwdata  = '0;
  logic [bspd_pkg::DataW-1:0]      cfg_prdata;
  logic                            cfg_pready;

  bspd_pkg::cfg_t                  cfg_shadow;
  deframe_mode_t                   mode;
  logic [bspd_pkg::SyncW-1:0]      sync_sr;
  logic [bspd_pkg::ByteW-1:0]      flag_sr;
  logic [bspd_pkg::ByteW-1:0]      pos;
  logic [bspd_pkg::ByteW-1:0]      nbytes;
  logic [bspd_pkg::ByteW-1:0]      len_sr;
  logic [bspd_pkg::ByteW-1:0]      body_acc;
  logic [bspd_pkg::CrcW-1:0]       crc_run;
  logic [bspd_pkg::CrcW-1:0]       crc_sr;

  bspd_pkg::result_t               frame_results[$];
  bspd_pkg::result_t               want;
  int unsigned                     errors        = 0;
  int unsigned                     symbols_sent  = 0;
  int unsigned                     results_seen  = 0;
  int unsigned                     frame_ends    = 0;
  int unsigned                     frames_sent   = 0;
  int unsigned                     regs_written  = 0;
  int unsigned                     cycle_count   = 0;
  int unsigned                     stall_asks    = 0;
  int unsigned                     stall_taken   = 0;
  bit                              quiet         = 1'b0;

  bit_stream_packet_deframer_crc16_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("** bit_stream_packet_deframer_crc16_core: FAILED **");
      $finish;
    end
  end

  // CRC-16, MSB first, one byte at a time
  function automatic logic [bspd_pkg::CrcW-1:0] crc_step(
      input logic [bspd_pkg::CrcW-1:0] acc, input logic [bspd_pkg::ByteW-1:0] data,
      input logic [bspd_pkg::CrcW-1:0] poly);
    logic [bspd_pkg::CrcW-1:0] r;
    r = acc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[bspd_pkg::CrcW-1] ? ((r << 1) ^ poly) : (r << 1);
    end
    return r;
  endfunction

  function automatic void clear_frame();
    mode     = HuntSync;
    sync_sr  = '0;
    flag_sr  = '0;
    pos      = '0;
    nbytes   = '0;
    len_sr   = '0;
    body_acc = '0;
    crc_run  = cfg_shadow.crc_seed;
    crc_sr   = '0;
  endfunction

  function automatic void expect_result(input bspd_pkg::result_t r);
    frame_results.insert(frame_results.size(), r);
  endfunction

  function automatic void predict_symbol(input logic [bspd_pkg::SymW-1:0] s);
    logic              shifts;
    logic              b;
    bspd_pkg::result_t r;
    shifts = (s == 8'd0) || (s == 8'd1);
    b      = s[0];
    r      = '0;
    case (mode)
      HuntSync: begin
        if (shifts) sync_sr = {sync_sr[bspd_pkg::SyncW-2:0], b};
        if (sync_sr == cfg_shadow.sync_word) mode = SeekFlag;
      end
      SeekFlag: begin
        if (pos < cfg_shadow.flag_window) begin
          if (shifts) flag_sr = {flag_sr[bspd_pkg::ByteW-2:0], b};
          pos = pos + 8'd1;
          if (flag_sr == cfg_shadow.flag_pattern) begin
            pos     = '0;
            crc_run = cfg_shadow.crc_seed;
            mode    = ReadLen;
          end
        end else begin
          clear_frame();
        end
      end
      ReadLen: begin
        if (shifts) len_sr = {len_sr[bspd_pkg::ByteW-2:0], b};
        pos = pos + 8'd1;
        if (pos >= 8) begin
          pos      = '0;
          crc_run  = crc_step(crc_run, len_sr, cfg_shadow.crc_polynomial);
          nbytes   = '0;
          body_acc = '0;
          mode     = (len_sr == 0) ? ReadCrc : ReadBody;
        end
      end
      ReadBody: begin
        if (pos == 0) body_acc = '0;
        if (shifts) body_acc = {body_acc[bspd_pkg::ByteW-2:0], b};
        pos = pos + 8'd1;
        if (pos >= 8) begin
          r.kind          = bspd_pkg::KindByte;
          r.payload_byte  = body_acc;
          r.byte_index    = nbytes;
          r.packet_length = len_sr;
          expect_result(r);
          crc_run = crc_step(crc_run, body_acc, cfg_shadow.crc_polynomial);
          pos     = '0;
          nbytes  = nbytes + 8'd1;
          if (nbytes >= len_sr) mode = ReadCrc;
        end
      end
      ReadCrc: begin
        if (shifts) crc_sr = {crc_sr[bspd_pkg::CrcW-2:0], b};
        pos = pos + 8'd1;
        if (pos >= 16) begin
          r.kind          = bspd_pkg::KindEnd;
          r.packet_length = len_sr;
          r.crc_good      = (crc_run == crc_sr);
          r.received_crc  = crc_sr;
          r.computed_crc  = crc_run;
          expect_result(r);
          clear_frame();
        end
      end
      default: clear_frame();
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got kind %0d data 0x%0h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = frame_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_tuser));
        check_field("payload_byte", 32'(want.payload_byte), 32'(out_tdata[7:0]));
        check_field("byte_index", 32'(want.byte_index), 32'(out_tdata[15:8]));
        check_field("packet_length", 32'(want.packet_length), 32'(out_tdata[23:16]));
        check_field("crc_good", 32'(want.crc_good), 32'(out_tdata[24]));
        check_field("received_crc", 32'(want.received_crc), 32'(out_tdata[40:25]));
        check_field("computed_crc", 32'(want.computed_crc), 32'(out_tdata[56:41]));
        check_field("spare bits", '0, 32'(out_tdata[63:57]));
        results_seen++;
        if (want.kind == bspd_pkg::KindEnd) frame_ends++;
      end
    end
  end

  // result side: random backpressure, plus long hold-offs on demand
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (stall_asks != stall_taken) begin
        stall_taken = stall_asks;
        hold_left   = LongStall;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= 27);
      end
    end
  end

  task automatic push_symbol(input logic [bspd_pkg::SymW-1:0] s);
    while (!quiet && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_symbol(s);
    symbols_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (frame_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // advance the deframer back to sync hunting
  task automatic flush_to_hunt();
    while (mode != HuntSync) push_symbol({7'd0, 1'($urandom_range(1))});
  endtask

  function automatic logic [31:0] reg_readback(input logic [2:0] idx);
    case (idx)
      bspd_pkg::RegSyncWord: return cfg_shadow.sync_word;
      bspd_pkg::RegFlagPat:  return {24'd0, cfg_shadow.flag_pattern};
      bspd_pkg::RegFlagWin:  return {24'd0, cfg_shadow.flag_window};
      bspd_pkg::RegCrcSeed:  return {16'd0, cfg_shadow.crc_seed};
      bspd_pkg::RegCrcPoly:  return {16'd0, cfg_shadow.crc_polynomial};
      default:               return '0;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= bspd_pkg::AddrW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      bspd_pkg::RegSyncWord: cfg_shadow.sync_word      = value;
      bspd_pkg::RegFlagPat:  cfg_shadow.flag_pattern   = value[7:0];
      bspd_pkg::RegFlagWin:  cfg_shadow.flag_window    = value[7:0];
      bspd_pkg::RegCrcSeed:  cfg_shadow.crc_seed       = value[15:0];
      bspd_pkg::RegCrcPoly:  cfg_shadow.crc_polynomial = value[15:0];
      default: ;
    endcase
    regs_written++;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    check_field("register readback", reg_readback(idx), cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apply_config(input logic [31:0] sync_val, input logic [31:0] flag_val,
                              input logic [31:0] win_val, input logic [31:0] seed_val,
                              input logic [31:0] poly_val);
    flush_to_hunt();
    drain_results();
    write_reg(bspd_pkg::RegSyncWord, sync_val);
    write_reg(bspd_pkg::RegFlagPat, flag_val);
    write_reg(bspd_pkg::RegFlagWin, win_val);
    write_reg(bspd_pkg::RegCrcSeed, seed_val);
    write_reg(bspd_pkg::RegCrcPoly, poly_val);
  endtask

  task automatic send_bits(input logic [31:0] value, input int nbits, input int noise_pct);
    for (int i = nbits - 1; i >= 0; i--) begin
      if ($urandom_range(99) < noise_pct) push_symbol(8'($urandom_range(255)));
      push_symbol({7'd0, value[i]});
    end
  endtask

  function automatic int flag_gap();
    int room;
    room = int'(cfg_shadow.flag_window) - 8;
    if (room <= 0) return 0;
    return $urandom_range(room < 20 ? room : 20);
  endfunction

  task automatic send_frame(input int len, input bit crc_ok, input int sync_noise,
                            input int body_noise, input int gap, input int flag_bits);
    logic [bspd_pkg::CrcW-1:0]  crc;
    logic [bspd_pkg::ByteW-1:0] body[$];
    crc = crc_step(cfg_shadow.crc_seed, 8'(len), cfg_shadow.crc_polynomial);
    for (int i = 0; i < len; i++) begin
      body.insert(body.size(), 8'($urandom_range(255)));
      crc = crc_step(crc, body[i], cfg_shadow.crc_polynomial);
    end
    if (!crc_ok) crc = crc ^ (16'd1 << $urandom_range(15));
    repeat ($urandom_range(4)) push_symbol(8'($urandom_range(255)));
    send_bits(cfg_shadow.sync_word, 32, sync_noise);
    repeat (gap) push_symbol(8'($urandom_range(2, 255)));
    send_bits({24'd0, cfg_shadow.flag_pattern}, flag_bits, 0);
    send_bits(32'(len), 8, body_noise);
    foreach (body[i]) send_bits({24'd0, body[i]}, 8, body_noise);
    send_bits({16'd0, crc}, 16, body_noise);
    frames_sent++;
  endtask

  // sync found, then no flag before the window runs out
  task automatic send_lost_flag();
    send_bits(cfg_shadow.sync_word, 32, 0);
    repeat (int'(cfg_shadow.flag_window) + 2) push_symbol(8'($urandom_range(2, 255)));
  endtask

  task automatic test_default_frames();
    push_symbol(8'hFF);
    push_symbol(8'h02);
    push_symbol(8'h80);
    send_frame(0, 1'b1, 20, 0, 0, 8);
    send_frame(1, 1'b1, 20, 0, 3, 8);
    send_frame(3, 1'b0, 0, 0, 5, 8);
    drain_results();
  endtask

  task automatic test_flag_window();
    send_lost_flag();
    apply_config(bspd_pkg::SyncWordRst, 32'h01, 32'd1, bspd_pkg::CrcSeedRst,
                 bspd_pkg::CrcPolyRst);
    send_frame(2, 1'b1, 0, 0, 0, 1);
    send_lost_flag();
    apply_config(bspd_pkg::SyncWordRst, 32'h00, 32'd8, bspd_pkg::CrcSeedRst,
                 bspd_pkg::CrcPolyRst);
    send_frame(1, 1'b1, 0, 0, 1, 0);
    apply_config(bspd_pkg::SyncWordRst, bspd_pkg::FlagPatRst, 32'd0, bspd_pkg::CrcSeedRst,
                 bspd_pkg::CrcPolyRst);
    send_bits(cfg_shadow.sync_word, 32, 0);
    push_symbol(8'h01);
    apply_config(bspd_pkg::SyncWordRst, bspd_pkg::FlagPatRst, 32'd255, bspd_pkg::CrcSeedRst,
                 bspd_pkg::CrcPolyRst);
    send_frame(2, 1'b1, 0, 0, 240, 8);
    send_lost_flag();
    drain_results();
  endtask

  task automatic test_zero_length();
    send_frame(0, 1'b1, 0, 0, flag_gap(), 8);
    send_frame(0, 1'b0, 0, 0, flag_gap(), 8);
    drain_results();
  endtask

  task automatic test_register_extremes();
    apply_config(32'hFFFF_FFFF, 32'hFF, 32'd255, 32'h0000, 32'hFFFF);
    send_frame(2, 1'b1, 0, 0, flag_gap(), 8);
    send_frame(1, 1'b0, 0, 0, flag_gap(), 8);
    apply_config(32'h0000_0000, 32'h00, 32'd1, 32'hFFFF, 32'h0000);
    send_frame(2, 1'b1, 0, 0, 0, 8);
    apply_config(32'hA5C3_0F96, 32'hFFFF_FF3C, 32'hFFFF_FF40, 32'hFFFF_1D0F, 32'hFFFF_8005);
    send_frame(4, 1'b1, 0, 0, flag_gap(), 8);
    send_frame(2, 1'b0, 0, 0, flag_gap(), 8);
    apply_config(bspd_pkg::SyncWordRst, bspd_pkg::FlagPatRst, bspd_pkg::FlagWinRst,
                 bspd_pkg::CrcSeedRst, bspd_pkg::CrcPolyRst);
    drain_results();
  endtask

  task automatic test_longest_frame();
    send_frame(255, 1'b1, 0, 0, flag_gap(), 8);
    drain_results();
  endtask

  task automatic test_backpressure();
    stall_asks++;
    send_frame(24, 1'b1, 0, 0, flag_gap(), 8);
    send_frame(3, 1'b0, 0, 0, flag_gap(), 8);
    drain_results();
  endtask

  task automatic test_random_stream();
    int unsigned first_symbol;
    int unsigned pick;
    int          len;
    first_symbol = symbols_sent;
    quiet = 1'b1;
    while (symbols_sent - first_symbol < RandomItems) begin
      if (symbols_sent - first_symbol > 300) quiet = 1'b0;
      if ($urandom_range(99) < 6) begin
        apply_config($urandom(),
                     {24'($urandom_range(255)), 8'($urandom_range(255))},
                     ($urandom_range(9) == 0) ? 32'($urandom_range(1, 11))
                                              : 32'($urandom_range(12, 255)),
                     $urandom(), $urandom());
      end
      len  = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_frame(len, $urandom_range(3) != 0, 0, 0, flag_gap(), 8);
      end else if (pick < 86) begin
        send_frame(len, 1'b1, 5, 4, flag_gap(), 8);
      end else if (pick < 92) begin
        send_lost_flag();
      end else begin
        repeat ($urandom_range(5, 40)) push_symbol(8'($urandom_range(255)));
      end
    end
    quiet = 1'b0;
    drain_results();
  endtask

  initial begin
    cfg_shadow.sync_word      = bspd_pkg::SyncWordRst;
    cfg_shadow.flag_pattern   = bspd_pkg::FlagPatRst;
    cfg_shadow.flag_window    = bspd_pkg::FlagWinRst;
    cfg_shadow.crc_seed       = bspd_pkg::CrcSeedRst;
    cfg_shadow.crc_polynomial = bspd_pkg::CrcPolyRst;
    clear_frame();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_frames();
    test_flag_window();
    test_zero_length();
    test_register_extremes();
    test_longest_frame();
    test_backpressure();
    test_random_stream();

    drain_results();
    $display("Run covered %0d symbols, %0d frames offered, %0d results (%0d frame ends),",
             symbols_sent, frames_sent, results_seen, frame_ends);
    $display("  %0d register writes with readback, long output stalls and idle gaps.",
             regs_written);
    if (errors == 0 && frame_results.size() == 0) begin
      $display("** bit_stream_packet_deframer_crc16_core: PASSED **");
    end else begin
      $display("%0t: %0d errors, %0d results still expected", $time, errors,
               frame_results.size());
      $display("** bit_stream_packet_deframer_crc16_core: FAILED **");
    end
    $finish;
  end

endmodule
